@@ hw/rtl/dqr_pkg.sv @@
`timescale 1ns / 1ps

package dqr_pkg;

  // Size limit of a reply frame in bytes
  localparam int DEF_MAX_FRAME = 512;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_TTL     = 1'b1;

  localparam logic [31:0] ADDRESS_RESET = 32'hC0A8_0401;
  localparam logic [31:0] TTL_RESET     = 32'd60;

  // Fixed reply header and answer bytes
  localparam logic [7:0] FLAGS_HI    = 8'h81;
  localparam logic [7:0] FLAGS_LO    = 8'h80;
  localparam logic [7:0] NAME_PTR_HI = 8'hC0;
  localparam logic [7:0] NAME_PTR_LO = 8'h0C;

  localparam int HEADER_LEN  = 12;
  localparam int ANSWER_LEN  = 16;
  localparam int TRAILER_LEN = 4;

  // One reply byte handed from the parser to the output stage
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drop;
    logic       answer;  // follow this byte with the answer record
  } dqr_job_t;

  // Reply header byte at header offset p for received byte b
  function automatic logic [7:0] header_byte(input logic [3:0] p, input logic [7:0] b);
    logic [7:0] r;
    case (p)
      4'd0, 4'd1: r = b;
      4'd2:       r = FLAGS_HI;
      4'd3:       r = FLAGS_LO;
      4'd5, 4'd7: r = 8'h01;
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

  // Answer record byte idx (1 to ANSWER_LEN)
  function automatic logic [7:0] answer_byte(input logic [4:0] idx, input logic [31:0] ttl,
                                             input logic [31:0] addr);
    logic [7:0] r;
    case (idx)
      5'd1:    r = NAME_PTR_HI;
      5'd2:    r = NAME_PTR_LO;
      5'd4:    r = 8'h01;
      5'd6:    r = 8'h01;
      5'd7:    r = ttl[31:24];
      5'd8:    r = ttl[23:16];
      5'd9:    r = ttl[15:8];
      5'd10:   r = ttl[7:0];
      5'd12:   r = 8'h04;
      5'd13:   r = addr[31:24];
      5'd14:   r = addr[23:16];
      5'd15:   r = addr[15:8];
      5'd16:   r = addr[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/dqr_in_if.sv @@
`timescale 1ns / 1ps

interface dqr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ hw/rtl/dqr_out_if.sv @@
`timescale 1ns / 1ps

interface dqr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_drop;

  modport source (output valid, output out_byte, output out_last, output out_drop,
                  input ready);
  modport sink (input valid, input out_byte, input out_last, input out_drop,
                output ready);
endinterface

@@ hw/rtl/dqr_cfg_if.sv @@
`timescale 1ns / 1ps

interface dqr_cfg_if import dqr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/dqr_parser.sv @@
`timescale 1ns / 1ps

module dqr_parser import dqr_pkg::*; #(
  parameter int MAX_FRAME = DEF_MAX_FRAME
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       job_valid,
  input  logic       job_ready,
  output dqr_job_t   job
);

  // Wide enough for a label target beyond the frame limit
  localparam int PosW = $clog2(MAX_FRAME + 257);
  localparam logic [PosW-1:0] LimitPos   = PosW'(MAX_FRAME - 17);
  localparam logic [PosW-1:0] HeaderEnd  = PosW'(HEADER_LEN - 1);
  localparam logic [PosW-1:0] NameStart  = PosW'(HEADER_LEN);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_NAME   = 2'd1;
  localparam logic [1:0] PH_TYPE   = 2'd2;

  logic            hold_valid;
  logic [7:0]      hold_byte;
  logic            hold_last;

  logic [PosW-1:0] pos, pos_next;
  logic [PosW-1:0] label_pos, label_pos_next;
  logic [1:0]      phase, phase_next;
  logic [2:0]      trail, trail_next;
  logic            finished, finished_next;

  logic            advance;
  logic [7:0]      rb;
  logic            complete;
  logic            drop;

  assign advance  = hold_valid && (finished || job_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= in_byte;
      hold_last <= in_last;
    end
  end

  always_comb begin
    rb             = hold_byte;
    complete       = 1'b0;
    pos_next       = pos + PosW'(1);
    label_pos_next = label_pos;
    phase_next     = phase;
    trail_next     = trail;
    finished_next  = finished;

    case (phase)
      PH_HEADER: begin
        rb = header_byte(pos[3:0], hold_byte);
        if (pos >= HeaderEnd) begin
          phase_next = PH_NAME;
        end
      end
      PH_NAME: begin
        if (pos == label_pos) begin
          if (hold_byte == 8'h00) begin
            phase_next = PH_TYPE;
            trail_next = 3'd0;
          end else begin
            label_pos_next = pos + PosW'(hold_byte) + PosW'(1);
          end
        end
      end
      PH_TYPE: begin
        trail_next = trail + 3'd1;
        complete   = (trail_next >= 3'(TRAILER_LEN));
      end
      default: begin
        rb = hold_byte;
      end
    endcase

    drop = (pos > LimitPos) || (hold_last && !complete);

    if (drop || complete) begin
      finished_next = 1'b1;
    end

    // A frame already answered or dropped only waits for its last byte
    if (finished) begin
      pos_next       = pos;
      label_pos_next = label_pos;
      phase_next     = phase;
      trail_next     = trail;
    end

    if (hold_last) begin
      pos_next       = '0;
      label_pos_next = NameStart;
      phase_next     = PH_HEADER;
      trail_next     = 3'd0;
      finished_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      label_pos <= NameStart;
      phase     <= PH_HEADER;
      trail     <= 3'd0;
      finished  <= 1'b0;
    end else if (advance) begin
      pos       <= pos_next;
      label_pos <= label_pos_next;
      phase     <= phase_next;
      trail     <= trail_next;
      finished  <= finished_next;
    end
  end

  assign job_valid  = advance && !finished;
  assign job.data   = rb;
  assign job.last   = drop;
  assign job.drop   = drop;
  assign job.answer = complete && !drop;

endmodule

@@ hw/rtl/dqr_emitter.sv @@
`timescale 1ns / 1ps

module dqr_emitter import dqr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  dqr_job_t    job,
  input  logic [31:0] answer_ttl,
  input  logic [31:0] answer_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_drop
);

  localparam logic [4:0] AnsLast = 5'(ANSWER_LEN);

  // Index of the next answer byte to load, zero when no burst is pending
  logic [4:0] ans_idx;
  logic       take;

  assign take      = out_valid && out_ready;
  assign job_ready = !out_valid || (out_ready && ans_idx == 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ans_idx   <= 5'd0;
    end else if (job_valid) begin
      out_valid <= 1'b1;
      ans_idx   <= job.answer ? 5'd1 : 5'd0;
    end else if (take) begin
      if (ans_idx != 5'd0) begin
        ans_idx <= (ans_idx == AnsLast) ? 5'd0 : ans_idx + 5'd1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid) begin
      out_byte <= job.data;
      out_last <= job.last;
      out_drop <= job.drop;
    end else if (take && ans_idx != 5'd0) begin
      out_byte <= answer_byte(ans_idx, answer_ttl, answer_address);
      out_last <= (ans_idx == AnsLast);
      out_drop <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/dns_query_responder_unit.sv @@
`timescale 1ns / 1ps

// Captive-portal DNS responder: turns a received query into a reply, byte by byte.
// query: one query byte per transfer, in_last on the final byte of the datagram.
// reply: one reply byte per transfer; out_last closes the reply frame, and
//   out_drop on that last byte tells the receiver to discard the whole frame.
// cfg:   register writes (answer_address, answer_ttl), always ready; write only
//   while no query byte is in flight.
// Each query byte passes through the input holding register, then the result
//   register, before it leaves as a reply byte.
// Throughput: one byte per cycle while the reply side takes them. The byte that
//   completes the question is followed by the 16-byte answer record from the
//   result register, and the next frame's query bytes wait until it is sent;
//   later bytes of the frame are absorbed at one per cycle without results.
// Reset clears the frame state, empties both registers and loads the default
//   address and TTL. A stalled reply side holds the result register; the
//   holding register still takes one more query byte before query.ready drops.
module dns_query_responder_unit import dqr_pkg::*; #(
  parameter int MAX_FRAME = DEF_MAX_FRAME
) (
  input logic       clk,
  input logic       rst,
  dqr_in_if.sink    query,
  dqr_out_if.source reply,
  dqr_cfg_if.sink   cfg
);

  logic [31:0] answer_address;
  logic [31:0] answer_ttl;

  dqr_job_t job;
  logic     job_valid;
  logic     job_ready;

  // Configuration registers; writes land at once
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_address <= ADDRESS_RESET;
      answer_ttl     <= TTL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ANSWER_ADDRESS: answer_address <= cfg.data;
        CFG_ANSWER_TTL:     answer_ttl     <= cfg.data;
        default:            answer_ttl     <= answer_ttl;
      endcase
    end
  end

  // Walk the header and question, rewrite header bytes, flag drops
  dqr_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (query.valid),
    .in_ready  (query.ready),
    .in_byte   (query.in_byte),
    .in_last   (query.in_last),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  // Hold the result byte and play out the answer record after the question
  dqr_emitter u_emitter (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (job_valid),
    .job_ready      (job_ready),
    .job            (job),
    .answer_ttl     (answer_ttl),
    .answer_address (answer_address),
    .out_valid      (reply.valid),
    .out_ready      (reply.ready),
    .out_byte       (reply.out_byte),
    .out_last       (reply.out_last),
    .out_drop       (reply.out_drop)
  );

endmodule
